// ===== rtl/gpvd_pkg.sv =====
// constants and types for the grid peak and valley detector
package gpvd_pkg;

    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int HEIGHT_W    = 16;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COLS_REG_W  = 7;
    localparam int ROWS_REG_W  = 11;
    localparam int ORD_W       = 16;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [COLS_REG_W-1:0] COLS_RESET = COLS_REG_W'(7);
    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = ROWS_REG_W'(6);
    localparam logic [COLS_REG_W-1:0] COLS_MIN   = COLS_REG_W'(3);
    localparam logic [ROWS_REG_W-1:0] ROWS_MIN   = ROWS_REG_W'(3);
    localparam logic [COLS_REG_W-1:0] COLS_MAX   = COLS_REG_W'(MAX_COLS);
    localparam logic [ROWS_REG_W-1:0] ROWS_MAX   = ROWS_REG_W'(MAX_ROWS);
    localparam logic [ORD_W-1:0]      ORD_MAX    = {ORD_W{1'b1}};

    // register index, taken from paddr bit 2
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    localparam logic KIND_PEAK   = 1'b0;
    localparam logic KIND_VALLEY = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample older;
        t_sample newer;
    } t_line_word;

    typedef struct packed {
        logic             kind;
        logic [ORD_W-1:0] ordinal;
        logic [COL_W-1:0] cell_col;
        logic [ROW_W-1:0] cell_row;
    } t_result;

endpackage

// ===== rtl/grid_peak_valley_detector.sv =====
// 4-neighbor peak and valley detector over a streamed height grid
// latency: a result is registered at the edge that accepts the item below the cell
// throughput: one item per cycle while input ready is high; line stores are read one position ahead of the stream
// output register plus skid register; input ready drops only when the skid register is full or reset is asserted
// reset: synchronous active low, clears positions, counts and handshake state, sizes go to 6x7
// line stores are not cleared; no cell is tested before two rows of the frame are in
module grid_peak_valley_detector
    import gpvd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [HEIGHT_W-1:0]   i_s_tdata,   // height
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [31:0]           o_m_tdata,   // cell_row, cell_col, ordinal
    output logic                  o_m_tuser,   // kind
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    logic [ROWS_REG_W-1:0] r_rows_reg;
    logic [COLS_REG_W-1:0] r_cols_reg;
    logic [ROWS_REG_W-1:0] rows_use;
    logic [COLS_REG_W-1:0] cols_use;
    logic                  cfg_wr;

    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [ORD_W-1:0]      r_peak, n_peak;
    logic [ORD_W-1:0]      r_valley, n_valley;
    t_sample               r_left;

    t_line_word            mem [MAX_COLS];
    t_line_word            r_rd_cur;
    t_line_word            r_rd_nxt;

    logic                  accept;
    logic                  col_wrap;
    logic                  row_wrap;
    logic                  tested;
    logic                  is_peak;
    logic                  is_valley;
    logic                  produce;
    t_sample               smp;
    t_sample               ctr;
    logic [ORD_W-1:0]      peak_inc;
    logic [ORD_W-1:0]      valley_inc;
    t_result               new_res;

    logic                  r_out_valid, n_out_valid;
    logic                  r_skid_valid, n_skid_valid;
    t_result               r_out, n_out;
    t_result               r_skid, n_skid;
    logic                  out_fire;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_ROWS: prdata = APB_DW'(r_rows_reg);
            REG_COLS: prdata = APB_DW'(r_cols_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_reg <= ROWS_RESET;
            r_cols_reg <= COLS_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ROWS) begin
                r_rows_reg <= pwdata[ROWS_REG_W-1:0];
            end else begin
                r_cols_reg <= pwdata[COLS_REG_W-1:0];
            end
        end
    end

    always_comb begin
        priority if (r_rows_reg < ROWS_MIN) rows_use = ROWS_MIN;
        else if (r_rows_reg > ROWS_MAX)     rows_use = ROWS_MAX;
        else                                rows_use = r_rows_reg;
        priority if (r_cols_reg < COLS_MIN) cols_use = COLS_MIN;
        else if (r_cols_reg > COLS_MAX)     cols_use = COLS_MAX;
        else                                cols_use = r_cols_reg;
    end

    // stream side
    assign o_s_tready = i_rst_n && !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign smp        = t_sample'(i_s_tdata[SAMPLE_BITS-1:0]);
    assign ctr        = r_rd_cur.newer;

    assign col_wrap = (COLS_REG_W'(r_col) + COLS_REG_W'(1)) == cols_use;
    assign row_wrap = (ROWS_REG_W'(r_row) + ROWS_REG_W'(1)) == rows_use;

    assign tested = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(1))
                    && ((COLS_REG_W'(r_col) + COLS_REG_W'(2)) <= cols_use);

    assign is_peak   = (r_rd_cur.older < ctr) && (smp < ctr) && (r_left < ctr)
                       && (r_rd_nxt.newer < ctr);
    assign is_valley = (r_rd_cur.older > ctr) && (smp > ctr) && (r_left > ctr)
                       && (r_rd_nxt.newer > ctr);
    assign produce   = accept && tested && (is_peak || is_valley);

    assign peak_inc   = (r_peak == ORD_MAX) ? r_peak : r_peak + ORD_W'(1);
    assign valley_inc = (r_valley == ORD_MAX) ? r_valley : r_valley + ORD_W'(1);

    always_comb begin
        new_res.kind     = is_peak ? KIND_PEAK : KIND_VALLEY;
        new_res.ordinal  = is_peak ? peak_inc : valley_inc;
        new_res.cell_col = r_col;
        new_res.cell_row = r_row - ROW_W'(1);
    end

    // position and counts
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_peak   = r_peak;
        n_valley = r_valley;
        if (cfg_wr) begin
            n_col    = '0;
            n_row    = '0;
            n_peak   = '0;
            n_valley = '0;
        end else if (accept) begin
            if (produce && is_peak) begin
                n_peak = peak_inc;
            end
            if (produce && !is_peak) begin
                n_valley = valley_inc;
            end
            if (col_wrap) begin
                n_col = '0;
                if (row_wrap) begin
                    n_row    = '0;
                    n_peak   = '0;
                    n_valley = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_peak   <= '0;
            r_valley <= '0;
            r_left   <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_peak   <= n_peak;
            r_valley <= n_valley;
            if (accept) begin
                r_left <= ctr;
            end
        end
    end

    // line stores: one word per column, read at the next position
    always_ff @(posedge i_clk) begin
        if (accept && !cfg_wr) begin
            mem[r_col] <= '{older: ctr, newer: smp};
        end
        r_rd_cur <= mem[n_col];
        r_rd_nxt <= mem[n_col + COL_W'(1)];
    end

    // output register and skid register
    assign out_fire = r_out_valid && i_m_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = new_res;
                n_out_valid = produce;
            end
        end else if (produce) begin
            n_skid       = new_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {r_out.ordinal, r_out.cell_col, r_out.cell_row};

endmodule
